// ----- design/kfc_pkg.sv -----
// Shared types and constants for the keypad four-function calculator.
// Depends on nothing; every other design file imports it.
package kfc_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned DISP_W          = 32;
    localparam int unsigned MAX_W           = 64;
    localparam logic [3:0]  DIGIT_MAX       = 4'd9;

    typedef enum logic [1:0] {
        KEY_DIGIT  = 2'd0,
        KEY_OP     = 2'd1,
        KEY_EQUALS = 2'd2,
        KEY_CLEAR  = 2'd3
    } t_key;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_DIV = 2'd2,
        OP_MUL = 2'd3
    } t_oper;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_OPER   = 2'd2,
        PH_SECOND = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_MUL_FIN,
        ST_DIV_FIN
    } t_ctrl_state;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_CLEAR,
        DP_LOAD,
        DP_APPEND,
        DP_SAVE,
        DP_ADD,
        DP_SUB,
        DP_MUL_START,
        DP_DIV_START,
        DP_MUL_STEP,
        DP_DIV_STEP,
        DP_MUL_DONE,
        DP_DIV_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   chain;   // write the result to the first operand as well
        logic   emit;    // load the output register this cycle
    } t_dp_cmd;

endpackage

// ----- design/kfc_if.sv -----
// Valid/ready channel interfaces for key words and result words.
// Depends on kfc_pkg.
interface kfc_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] digit;
    logic [1:0] operator_code;

    modport source(output valid, mode, digit, operator_code, input ready);
    modport sink(input valid, mode, digit, operator_code, output ready);
endinterface

interface kfc_res_if;
    import kfc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DISP_W-1:0] display_value;
    logic                     div_by_zero;

    modport source(output valid, display_value, div_by_zero, input ready);
    modport sink(input valid, display_value, div_by_zero, output ready);
endinterface

// ----- design/kfc_ctrl.sv -----
// Controller: entry phase, pending operator and the multi-cycle sequencer.
// Depends on kfc_pkg; drives kfc_dp through a t_dp_cmd word.
module kfc_ctrl #(
    parameter int unsigned VALUE_WIDTH = kfc_pkg::VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_key_valid,
    output logic             o_key_ready,
    input  kfc_pkg::t_key    i_mode,
    input  logic [3:0]       i_digit,
    input  kfc_pkg::t_oper   i_operator_code,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output kfc_pkg::t_dp_cmd o_cmd
);
    import kfc_pkg::*;

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    t_ctrl_state     r_state, n_state;
    t_phase          r_phase, n_phase;
    t_oper           r_pend, n_pend;
    logic            r_chain, n_chain;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic            r_res_valid, n_res_valid;

    logic w_ready, w_fire, w_apply, w_digit_ok, w_long_op, w_emit;

    assign w_ready    = (r_state == ST_IDLE) && (!r_res_valid || i_res_ready);
    assign w_fire     = w_ready && i_key_valid;
    assign w_digit_ok = (i_digit <= DIGIT_MAX);
    assign w_apply    = (r_phase == PH_SECOND)
                        && ((i_mode == KEY_OP) || (i_mode == KEY_EQUALS));
    assign w_long_op  = (r_pend == OP_MUL) || (r_pend == OP_DIV);

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_chain = r_chain;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    unique case (i_mode)
                        KEY_CLEAR: begin
                            n_phase = PH_IDLE;
                            n_pend  = OP_ADD;
                        end
                        KEY_DIGIT: begin
                            if (w_digit_ok) begin
                                if (r_phase == PH_IDLE && i_digit != 4'd0) begin
                                    n_phase = PH_FIRST;
                                end else if (r_phase == PH_OPER) begin
                                    n_phase = PH_SECOND;
                                end
                            end
                        end
                        KEY_OP: begin
                            n_pend = i_operator_code;
                            if (r_phase != PH_IDLE) begin
                                n_phase = PH_OPER;
                            end
                            n_chain = 1'b1;
                        end
                        KEY_EQUALS: begin
                            if (r_phase == PH_SECOND) begin
                                n_phase = PH_IDLE;
                            end
                            n_chain = 1'b0;
                        end
                    endcase
                    if (w_apply && w_long_op) begin
                        n_state = (r_pend == OP_MUL) ? ST_MUL : ST_DIV;
                        n_cnt   = '0;
                    end
                end
            end
            ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_MUL_FIN;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DIV_FIN;
                end
            end
            ST_MUL_FIN, ST_DIV_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs: command word for the datapath
    always_comb begin
        o_cmd.op    = DP_IDLE;
        o_cmd.chain = r_chain;
        o_cmd.emit  = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    w_emit      = !(w_apply && w_long_op);
                    o_cmd.chain = (i_mode == KEY_OP);
                    unique case (i_mode)
                        KEY_CLEAR: o_cmd.op = DP_CLEAR;
                        KEY_DIGIT: begin
                            if (w_digit_ok) begin
                                if (r_phase == PH_IDLE || r_phase == PH_OPER) begin
                                    o_cmd.op = DP_LOAD;
                                end else begin
                                    o_cmd.op = DP_APPEND;
                                end
                            end
                        end
                        KEY_OP, KEY_EQUALS: begin
                            if (w_apply) begin
                                unique case (r_pend)
                                    OP_ADD: o_cmd.op = DP_ADD;
                                    OP_SUB: o_cmd.op = DP_SUB;
                                    OP_MUL: o_cmd.op = DP_MUL_START;
                                    OP_DIV: o_cmd.op = DP_DIV_START;
                                endcase
                            end else if (i_mode == KEY_OP
                                         && (r_phase == PH_IDLE || r_phase == PH_FIRST)) begin
                                o_cmd.op = DP_SAVE;
                            end
                        end
                    endcase
                end
            end
            ST_MUL:     o_cmd.op = DP_MUL_STEP;
            ST_DIV:     o_cmd.op = DP_DIV_STEP;
            ST_MUL_FIN: begin
                o_cmd.op = DP_MUL_DONE;
                w_emit   = 1'b1;
            end
            ST_DIV_FIN: begin
                o_cmd.op = DP_DIV_DONE;
                w_emit   = 1'b1;
            end
            default: o_cmd.op = DP_IDLE;
        endcase
        o_cmd.emit = w_emit;
    end

    // hold the result word until the sink takes it
    always_comb begin
        if (w_emit) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_pend      <= OP_ADD;
            r_chain     <= 1'b0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_chain     <= n_chain;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_key_ready = w_ready;
    assign o_res_valid = r_res_valid;

endmodule

// ----- design/kfc_dp.sv -----
// Datapath: current value, first operand, shift-add multiplier,
// restoring divider and the result register. Depends on kfc_pkg.
module kfc_dp #(
    parameter int unsigned VALUE_WIDTH = kfc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kfc_pkg::t_dp_cmd                  i_cmd,
    input  logic [3:0]                        i_digit,
    output logic signed [kfc_pkg::DISP_W-1:0] o_display_value,
    output logic                              o_div_by_zero
);
    import kfc_pkg::*;

    localparam int unsigned W = VALUE_WIDTH;

    logic [W-1:0] r_cur, n_cur;
    logic [W-1:0] r_first, n_first;
    logic [W-1:0] r_acc, n_acc;      // product accumulator / remainder
    logic [W-1:0] r_a, n_a;          // shifted multiplicand
    logic [W-1:0] r_b, n_b;          // multiplier / dividend-quotient shifter
    logic [W-1:0] r_d, n_d;          // divisor magnitude
    logic         r_neg, n_neg;
    logic         n_dz;

    logic [W-1:0] w_res;
    logic         w_write;
    logic [W:0]   w_rem_sh, w_diff;
    logic         w_ge;
    logic [W-1:0] w_mag_a, w_mag_b;
    logic [MAX_W-1:0] w_wide;
    logic signed [DISP_W-1:0] r_disp;
    logic         r_dz;

    assign w_mag_a  = r_first[W-1] ? (~r_first + 1'b1) : r_first;
    assign w_mag_b  = r_cur[W-1]   ? (~r_cur + 1'b1)   : r_cur;
    assign w_rem_sh = {r_acc, r_b[W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_d};
    assign w_ge     = (w_rem_sh >= {1'b0, r_d});

    always_comb begin
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_d     = r_d;
        n_neg   = r_neg;
        n_dz    = 1'b0;
        w_res   = r_cur;
        w_write = 1'b0;
        n_first = r_first;
        unique case (i_cmd.op)
            DP_CLEAR: begin
                w_res   = '0;
                w_write = 1'b1;
                n_first = '0;
            end
            DP_LOAD: begin
                w_res   = W'(i_digit);
                w_write = 1'b1;
            end
            DP_APPEND: begin
                w_res   = (r_cur << 3) + (r_cur << 1) + W'(i_digit);
                w_write = 1'b1;
            end
            DP_SAVE: n_first = r_cur;
            DP_ADD: begin
                w_res   = r_first + r_cur;
                w_write = 1'b1;
            end
            DP_SUB: begin
                w_res   = r_first - r_cur;
                w_write = 1'b1;
            end
            DP_MUL_START: begin
                n_acc = '0;
                n_a   = r_first;
                n_b   = r_cur;
            end
            DP_DIV_START: begin
                n_acc = '0;
                n_b   = w_mag_a;
                n_d   = w_mag_b;
                n_neg = r_first[W-1] ^ r_cur[W-1];
            end
            DP_MUL_STEP: begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = r_a << 1;
                n_b = r_b >> 1;
            end
            DP_DIV_STEP: begin
                n_acc = w_ge ? w_diff[W-1:0] : w_rem_sh[W-1:0];
                n_b   = {r_b[W-2:0], w_ge};
            end
            DP_MUL_DONE: begin
                w_res   = r_acc;
                w_write = 1'b1;
            end
            DP_DIV_DONE: begin
                if (r_d == '0) begin
                    w_res = '0;
                    n_dz  = 1'b1;
                end else begin
                    w_res = r_neg ? (~r_b + 1'b1) : r_b;
                end
                w_write = 1'b1;
            end
            default: begin
                w_write = 1'b0;
            end
        endcase
        n_cur = w_write ? w_res : r_cur;
        // an operator key chains the result into the first operand
        if (w_write && i_cmd.chain && i_cmd.op != DP_CLEAR) begin
            n_first = w_res;
        end
    end

    assign w_wide = MAX_W'(n_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_first <= '0;
        end else begin
            r_cur   <= n_cur;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_d   <= n_d;
        r_neg <= n_neg;
        if (i_cmd.emit) begin
            r_disp <= $signed(w_wide[DISP_W-1:0]);
            r_dz   <= n_dz;
        end
    end

    assign o_display_value = r_disp;
    assign o_div_by_zero   = r_dz;

endmodule

// ----- design/keypad_four_function_calculator_unit.sv -----
// Keypad four-function calculator: one key word in, one result word out.
// Digit, clear, add, subtract and ignored keys give their result word in
// the cycle after acceptance; multiply and divide first run the
// one-bit-per-cycle shift-add / restoring divide loop in the sequencer.
// Throughput: one key per cycle unless results stall or mul/div runs.
// Reset (i_rst_n low, synchronous) clears phase, values and operator to add.
module keypad_four_function_calculator_unit #(
    parameter int unsigned VALUE_WIDTH = kfc_pkg::VALUE_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kfc_key_if.sink         i_key,
    kfc_res_if.source       o_res
);
    import kfc_pkg::*;

    // Command word from the controller to the datapath.  The controller
    // owns the entry phase and pending operator; the datapath owns the
    // values and the arithmetic.
    t_dp_cmd w_cmd;

    // Controller: accepts a key word only when the sequencer is idle and
    // the result register is empty or draining this cycle, so a word that
    // is being taken does not block the next key.
    kfc_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_valid    (i_key.valid),
        .o_key_ready    (i_key.ready),
        .i_mode         (t_key'(i_key.mode)),
        .i_digit        (i_key.digit),
        .i_operator_code(t_oper'(i_key.operator_code)),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_cmd          (w_cmd)
    );

    // Datapath: digits are applied in the accept cycle, so the digit field
    // is read straight from the channel; mul/div run on latched operands.
    kfc_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_digit        (i_key.digit),
        .o_display_value(o_res.display_value),
        .o_div_by_zero  (o_res.div_by_zero)
    );

endmodule

// ----- sim/kfc_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the keypad calculator: watches the key and result channels,
// predicts each result word from the keys accepted, and counts mismatches.
// Depends on kfc_pkg and the channel interfaces in kfc_if.sv.
module kfc_result_checker #(
    parameter int unsigned VALUE_WIDTH = kfc_pkg::VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kfc_key_if   i_key,
    kfc_res_if   i_res,
    output int   o_fail_count,
    output int   o_words_owed,
    output int   o_words_checked,
    output int   o_zero_div_seen
);
    import kfc_pkg::*;

    localparam int unsigned RADIX        = 10;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DISP_W-1:0] display_value;
        logic              div_by_zero;
    } t_calc_word;

    // Shadow of the calculator's entry state.
    t_phase                 entry_ph;
    logic [VALUE_WIDTH-1:0] run_value;
    logic [VALUE_WIDTH-1:0] first_opnd;
    t_oper                  stored_op;

    t_calc_word owed_q[$];
    int         fails     = 0;
    int         owed      = 0;
    int         checked   = 0;
    int         dz_seen   = 0;

    assign o_fail_count    = fails;
    assign o_words_owed    = owed;
    assign o_words_checked = checked;
    assign o_zero_div_seen = dz_seen;

    function automatic logic [VALUE_WIDTH-1:0] trunc_quotient(
        input logic [VALUE_WIDTH-1:0] num,
        input logic [VALUE_WIDTH-1:0] den
    );
        logic [VALUE_WIDTH-1:0] mag_n;
        logic [VALUE_WIDTH-1:0] mag_d;
        logic [VALUE_WIDTH-1:0] quot;
        mag_n = num[VALUE_WIDTH-1] ? -num : num;
        mag_d = den[VALUE_WIDTH-1] ? -den : den;
        quot  = mag_n / mag_d;
        if (num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1]) begin
            quot = -quot;
        end
        return quot;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] apply_oper(
        input  t_oper                  op,
        input  logic [VALUE_WIDTH-1:0] lhs,
        input  logic [VALUE_WIDTH-1:0] rhs,
        output logic                   zero_div
    );
        logic [VALUE_WIDTH-1:0] res;
        zero_div = 1'b0;
        case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
                if (rhs == '0) begin
                    zero_div = 1'b1;
                    res      = '0;
                end else begin
                    res = trunc_quotient(lhs, rhs);
                end
            end
        endcase
        return res;
    endfunction

    task automatic reset_calc();
        entry_ph   = PH_IDLE;
        run_value  = '0;
        first_opnd = '0;
        stored_op  = OP_ADD;
    endtask

    task automatic predict_key(
        input  t_key       mode,
        input  logic [3:0] digit,
        input  t_oper      op,
        output t_calc_word word
    );
        logic zero_div;
        zero_div = 1'b0;
        case (mode)
            KEY_CLEAR: reset_calc();
            KEY_DIGIT: begin
                if (digit <= DIGIT_MAX) begin
                    case (entry_ph)
                        PH_IDLE: begin
                            run_value = VALUE_WIDTH'(digit);
                            if (digit != 4'd0) begin
                                entry_ph = PH_FIRST;
                            end
                        end
                        PH_OPER: begin
                            run_value = VALUE_WIDTH'(digit);
                            entry_ph  = PH_SECOND;
                        end
                        default: run_value = run_value * VALUE_WIDTH'(RADIX)
                                             + VALUE_WIDTH'(digit);
                    endcase
                end
            end
            KEY_OP: begin
                case (entry_ph)
                    PH_IDLE: begin
                        first_opnd = run_value;
                        stored_op  = op;
                    end
                    PH_FIRST: begin
                        first_opnd = run_value;
                        stored_op  = op;
                        entry_ph   = PH_OPER;
                    end
                    PH_OPER: stored_op = op;
                    default: begin
                        run_value  = apply_oper(stored_op, first_opnd, run_value, zero_div);
                        first_opnd = run_value;
                        stored_op  = op;
                        entry_ph   = PH_OPER;
                    end
                endcase
            end
            default: begin
                // equals only acts once a second operand is in
                if (entry_ph == PH_SECOND) begin
                    run_value = apply_oper(stored_op, first_opnd, run_value, zero_div);
                    entry_ph  = PH_IDLE;
                end
            end
        endcase
        word.display_value = DISP_W'(run_value);
        word.div_by_zero   = zero_div;
    endtask

    task automatic log_failure(input string msg);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_calc_word want;
        t_calc_word got;
        if (!i_rst_n) begin
            reset_calc();
            owed_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.display_value = i_res.display_value;
                got.div_by_zero   = i_res.div_by_zero;
                if (owed_q.size() == 0) begin
                    log_failure($sformatf("result word %0d/%0b with nothing owed",
                                          $signed(got.display_value), got.div_by_zero));
                end else begin
                    want = owed_q.pop_front();
                    checked++;
                    if (got.div_by_zero === 1'b1) begin
                        dz_seen++;
                    end
                    if (got.display_value !== want.display_value) begin
                        log_failure($sformatf("display_value expected %0d got %0d",
                                              $signed(want.display_value),
                                              $signed(got.display_value)));
                    end
                    if (got.div_by_zero !== want.div_by_zero) begin
                        log_failure($sformatf("div_by_zero expected %0b got %0b",
                                              want.div_by_zero, got.div_by_zero));
                    end
                end
            end
            if (i_key.valid && i_key.ready) begin
                predict_key(t_key'(i_key.mode), i_key.digit, t_oper'(i_key.operator_code),
                            want);
                owed_q.push_back(want);
            end
        end
        owed = owed_q.size();
    end

endmodule

// ----- sim/keypad_four_function_calculator_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the keypad calculator: drives key words with random pacing,
// stalls the result side, and reports the verdict from kfc_result_checker.
// Depends on kfc_pkg, kfc_if.sv, the calculator RTL and kfc_result_checker.
module keypad_four_function_calculator_unit_tb;
    import kfc_pkg::*;

    localparam int unsigned VW             = VALUE_WIDTH_DEF;
    localparam int unsigned RADIX          = 10;
    localparam int          TARGET_KEYS    = 1550;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    kfc_key_if key_ch ();
    kfc_res_if res_ch ();

    // Pacing knobs, changed between stimulus phases.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    int keys_counted = 0;
    int keys_noise   = 0;
    int quiet_cycles = 0;

    int fail_count;
    int words_owed;
    int words_checked;
    int zero_div_seen;

    keypad_four_function_calculator_unit #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_key  (key_ch),
        .o_res  (res_ch)
    );

    kfc_result_checker #(
        .VALUE_WIDTH(VW)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          (key_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_words_owed   (words_owed),
        .o_words_checked(words_checked),
        .o_zero_div_seen(zero_div_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: drop ready at random on each falling edge, per the current
    // stall percentage. Zero percent keeps ready high every cycle.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any accepted word on either channel restarts the count, so a
    // hung handshake or a lost result ends the run instead of spinning forever.
    always @(posedge i_clk) begin
        if (!i_rst_n || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word accepted for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one key word. Entered and left at a falling edge. Fields that the
    // key kind does not use carry random bits so every input bit toggles.
    task automatic press(
        input t_key       mode,
        input logic [3:0] digit,
        input t_oper      op,
        input bit         counted
    );
        // insert sender gaps before the word
        while ($urandom_range(99) < sender_idle_pct) begin
            key_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        key_ch.valid         <= 1'b1;
        key_ch.mode          <= mode;
        key_ch.digit         <= (mode == KEY_DIGIT) ? digit : 4'($urandom_range(15));
        key_ch.operator_code <= (mode == KEY_OP) ? op : 2'($urandom_range(3));
        // hold the word until the block takes it
        @(posedge i_clk);
        while (!key_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        if (counted) begin
            keys_counted++;
        end else begin
            keys_noise++;
        end
    endtask

    // Stop sending and wait until every owed result word has come back.
    task automatic wait_for_results();
        key_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (words_owed != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Type a decimal number, most significant digit first. Values wider than
    // the datapath wrap inside the block, which is part of what gets checked.
    task automatic enter_number(input longint unsigned value);
        logic [3:0] digs [0:19];
        int         n;
        n = 0;
        do begin
            digs[n] = 4'(value % RADIX);
            value   = value / RADIX;
            n++;
        end while (value != 0);
        for (int i = n - 1; i >= 0; i--) begin
            press(KEY_DIGIT, digs[i], OP_ADD, 1'b1);
        end
    endtask

    // Mostly short operands so division gives nonzero quotients; zero often
    // enough to hit the divide-by-zero flag; now and then ten digits.
    task automatic enter_random_number();
        longint unsigned v;
        int              r;
        r = $urandom_range(99);
        if (r < 10) begin
            v = '0;
        end else if (r < 70) begin
            v = 64'($urandom_range(999, 1));
        end else if (r < 90) begin
            v = 64'($urandom_range(99999, 1));
        end else begin
            v = 64'($urandom_range(99999)) * 64'd100000 + 64'($urandom_range(99999));
        end
        enter_number(v);
    endtask

    function automatic longint unsigned corner_value(input int idx);
        case (idx)
            0:       return 64'd2147483648;   // wraps to the most negative value
            1:       return 64'd4294967295;   // wraps to minus one
            2:       return 64'd2147483647;
            3:       return 64'd0;
            4:       return 64'd1;
            5:       return 64'd9999999999;
            default: return 64'd65536;
        endcase
    endfunction

    // Clear, then one operation on boundary operands. With force_min_div set,
    // divide the most negative value by minus one.
    task automatic corner_expression(input bit force_min_div);
        t_oper op;
        op = force_min_div ? OP_DIV : t_oper'($urandom_range(3));
        press(KEY_CLEAR, 4'd0, OP_ADD, 1'b1);
        enter_number(force_min_div ? corner_value(0) : corner_value($urandom_range(6)));
        press(KEY_OP, 4'd0, op, 1'b1);
        if (force_min_div || (op == OP_DIV && $urandom_range(1) == 0)) begin
            enter_number(corner_value(1));
        end else begin
            enter_number(corner_value($urandom_range(6)));
        end
        press(KEY_EQUALS, 4'd0, OP_ADD, 1'b1);
    endtask

    // A well-formed chain: number (op number)+ and usually equals. Sometimes
    // replace the operator, sometimes leave the chain open for the next one.
    task automatic random_expression();
        int n_ops;
        int ending;
        if ($urandom_range(3) == 0) begin
            press(KEY_CLEAR, 4'd0, OP_ADD, 1'b1);
        end
        enter_random_number();
        n_ops = $urandom_range(4, 1);
        for (int i = 0; i < n_ops; i++) begin
            press(KEY_OP, 4'd0, t_oper'($urandom_range(3)), 1'b1);
            if ($urandom_range(7) == 0) begin
                press(KEY_OP, 4'd0, t_oper'($urandom_range(3)), 1'b1);
            end
            enter_random_number();
        end
        ending = $urandom_range(99);
        if (ending < 85) begin
            press(KEY_EQUALS, 4'd0, OP_ADD, 1'b1);
            // operator from idle: latch the answer as the next first operand
            if (ending >= 70) begin
                press(KEY_OP, 4'd0, t_oper'($urandom_range(3)), 1'b1);
            end
        end
    endtask

    initial begin
        int goal;
        int r;

        // Hold every input at a known value from time zero.
        i_rst_n              = 1'b0;
        key_ch.valid         = 1'b0;
        key_ch.mode          = KEY_DIGIT;
        key_ch.digit         = 4'd0;
        key_ch.operator_code = OP_ADD;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: walk every phase, early equals in idle/first/operator,
        // ignored out-of-range digits, operator replacement, divide by zero,
        // chaining, and clear from each of the four phases.
        press(KEY_CLEAR,  4'd0,  OP_ADD, 1'b1);   // clear in idle
        press(KEY_EQUALS, 4'd0,  OP_ADD, 1'b1);   // early equals, idle
        press(KEY_DIGIT,  4'd0,  OP_ADD, 1'b1);   // leading zero stays idle
        press(KEY_DIGIT,  4'd12, OP_ADD, 1'b1);   // out of range, ignored
        press(KEY_OP,     4'd0,  OP_MUL, 1'b1);   // operator from idle
        press(KEY_DIGIT,  4'd9,  OP_ADD, 1'b1);
        press(KEY_EQUALS, 4'd0,  OP_ADD, 1'b1);   // early equals, first number
        press(KEY_DIGIT,  4'd15, OP_ADD, 1'b1);   // out of range, ignored
        press(KEY_CLEAR,  4'd0,  OP_ADD, 1'b1);   // clear in first number
        press(KEY_DIGIT,  4'd4,  OP_ADD, 1'b1);
        press(KEY_OP,     4'd0,  OP_ADD, 1'b1);
        press(KEY_EQUALS, 4'd0,  OP_ADD, 1'b1);   // early equals, operator given
        press(KEY_OP,     4'd0,  OP_SUB, 1'b1);   // replace pending operator
        press(KEY_OP,     4'd0,  OP_DIV, 1'b1);
        press(KEY_DIGIT,  4'd0,  OP_ADD, 1'b1);
        press(KEY_EQUALS, 4'd0,  OP_ADD, 1'b1);   // divide by zero
        press(KEY_DIGIT,  4'd8,  OP_ADD, 1'b1);
        press(KEY_OP,     4'd0,  OP_MUL, 1'b1);
        press(KEY_CLEAR,  4'd0,  OP_ADD, 1'b1);   // clear in operator given
        press(KEY_DIGIT,  4'd6,  OP_ADD, 1'b1);
        press(KEY_OP,     4'd0,  OP_MUL, 1'b1);
        press(KEY_DIGIT,  4'd9,  OP_ADD, 1'b1);
        press(KEY_OP,     4'd0,  OP_SUB, 1'b1);   // chain: apply multiply
        press(KEY_DIGIT,  4'd7,  OP_ADD, 1'b1);
        press(KEY_CLEAR,  4'd0,  OP_ADD, 1'b1);   // clear in second number

        // Pause the sender until every owed word is back.
        wait_for_results();

        // Random part in four pacing modes: free-running, sender gaps,
        // receiver stalls, then both. Drain between modes.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            goal = keys_counted + TARGET_KEYS / 4;
            corner_expression(1'b1);
            while (keys_counted < goal) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    // noise: any key kind with any field bits
                    press(t_key'($urandom_range(3)), 4'($urandom_range(15)),
                          t_oper'($urandom_range(3)), 1'b0);
                end else if (r < 16) begin
                    corner_expression(1'b0);
                end else begin
                    random_expression();
                end
            end
            wait_for_results();
        end

        // Let any late or stray word show up before the verdict.
        repeat (VW + 8) @(negedge i_clk);

        $display("Sent %0d key words in chains plus %0d noise words across four pacing modes.",
                 keys_counted, keys_noise);
        $display("Checked %0d result words, %0d of them flagging a zero divisor.",
                 words_checked, zero_div_seen);
        if (fail_count == 0 && words_owed == 0) begin
            $display("Regression PASS");
        end else begin
            if (words_owed != 0) begin
                $display("%0d result words never arrived", words_owed);
            end
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- keypad_four_function_calculator_unit.f -----
design/kfc_pkg.sv
design/kfc_if.sv
design/kfc_ctrl.sv
design/kfc_dp.sv
design/keypad_four_function_calculator_unit.sv
sim/kfc_result_checker.sv
sim/keypad_four_function_calculator_unit_tb.sv
